/* hw/rtl/ctt_pkg.sv */
`default_nettype none
package ctt_pkg;
   localparam int MaxTrackers = 16;
   localparam int SlotW = $clog2(MaxTrackers);
   localparam int CntW = SlotW + 1;
   localparam int IdW = 5;
   localparam int CsrIdxW = 2;
   localparam int CsrDataW = 23;

   localparam logic [CsrIdxW-1:0] CSR_MIN_AREA  = 2'd0;
   localparam logic [CsrIdxW-1:0] CSR_RADIUS    = 2'd1;
   localparam logic [CsrIdxW-1:0] CSR_STABILITY = 2'd2;

   typedef struct packed {
      logic [22:0] comp_area;
      logic [10:0] comp_left;
      logic [10:0] comp_top;
      logic [11:0] comp_width;
      logic [11:0] comp_height;
      logic [14:0] centre_x;
      logic [14:0] centre_y;
      logic        last_in_frame;
   } req_type;

   typedef struct packed {
      logic [IdW-1:0] track_id;
      logic        was_skipped;
      logic        is_new;
      logic        table_full;
      logic        locked_now;
      logic        is_locked;
      logic [7:0]  stable_count;
      logic [10:0] box_left;
      logic [10:0] box_top;
      logic [11:0] box_width;
      logic [11:0] box_height;
      logic        frame_done;
   } rsp_type;

   typedef struct packed {
      logic [CsrIdxW-1:0]  index;
      logic [CsrDataW-1:0] data;
   } csr_type;

   // Contents of one tracker cell.
   typedef struct packed {
      logic        valid;
      logic        locked;
      logic [7:0]  stable;
      logic [22:0] max_area;
      logic [10:0] left;
      logic [10:0] top;
      logic [11:0] width;
      logic [11:0] height;
   } slot_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_SCAN, ST_WAIT, ST_UPDATE, ST_OUT
   } state_type;
endpackage
`default_nettype wire

/* hw/rtl/ctt_if.sv */
`default_nettype none
interface ctt_req_if;
   import ctt_pkg::*;
   logic valid;
   logic ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface ctt_rsp_if;
   import ctt_pkg::*;
   logic valid;
   logic ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface ctt_csr_if;
   import ctt_pkg::*;
   logic valid;
   logic ready;
   csr_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

/* hw/rtl/ctt_cell.sv */
`default_nettype none
// One tracker slot. The contents rotate through the ring: each cycle of a
// rotation this cell takes its neighbor's contents, or new contents at the
// head of the ring.
module ctt_cell (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              shift,
   input  wire ctt_pkg::slot_type slot_in,
   output ctt_pkg::slot_type      slot_out
);
   import ctt_pkg::*;
   slot_type slot_ff;
   logic     valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (shift) begin
         valid_ff <= slot_in.valid;
      end
      if (shift) begin
         slot_ff <= slot_in;
      end
   end

   always_comb begin
      slot_out = slot_ff;
      slot_out.valid = valid_ff;
   end
endmodule
`default_nettype wire

/* hw/rtl/ctt_dist.sv */
`default_nettype none
// Squared distance from the head slot's box centre to the centroid: the
// products are registered and the sum is formed combinationally from them.
module ctt_dist (
   input  wire logic        clock,
   input  wire logic [14:0] centre_x,
   input  wire logic [14:0] centre_y,
   input  wire logic [10:0] left,
   input  wire logic [10:0] top,
   input  wire logic [11:0] width,
   input  wire logic [11:0] height,
   output logic [31:0]      dist_sq
);
   logic [15:0] tx, ty, dx, dy;
   logic [31:0] dx_sq_ff, dy_sq_ff;
   logic [31:0] dx_sq_in, dy_sq_in;
   logic [32:0] sum;

   always_comb begin
      tx = {1'b0, left, 4'b0} + {1'b0, width, 3'b0};
      ty = {1'b0, top, 4'b0} + {1'b0, height, 3'b0};
      dx = ({1'b0, centre_x} >= tx) ? ({1'b0, centre_x} - tx) : (tx - {1'b0, centre_x});
      dy = ({1'b0, centre_y} >= ty) ? ({1'b0, centre_y} - ty) : (ty - {1'b0, centre_y});
      dx_sq_in = dx * dx;
      dy_sq_in = dy * dy;
      sum = {1'b0, dx_sq_ff} + {1'b0, dy_sq_ff};
      // Saturate: any radius squared fits in 32 bits, so a clipped sum still fails.
      dist_sq = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
   end

   always_ff @(posedge clock) begin
      dx_sq_ff <= dx_sq_in;
      dy_sq_ff <= dy_sq_in;
   end
endmodule
`default_nettype wire

/* hw/rtl/centroid_tracker_table.sv */
// An accepted item passes through one full ring rotation to measure distances,
// a wait state for the last distance to settle, and a second rotation to write
// back the slot. One item at a time; the next is accepted in the cycle after
// the result is taken. Reset clears all slots' valid bits, the allocation
// pointer and loads the register defaults.
`default_nettype none
module centroid_tracker_table (
   input  wire logic clock,
   input  wire logic reset,
   ctt_req_if.sink   req,
   ctt_rsp_if.source rsp,
   ctt_csr_if.sink   csr
);
   import ctt_pkg::*;

   state_type state_ff, state_in;
   req_type   item_ff;
   logic [22:0] min_area_ff;
   logic [11:0] radius_ff;
   logic [7:0]  stab_ff;
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic [CntW-1:0] next_slot_ff;
   logic [31:0] best_ff;
   logic        found_ff;
   logic [SlotW-1:0] best_idx_ff;
   logic [SlotW-1:0] dist_idx_ff;
   logic        dist_vld_ff, dist_slot_vld_ff;
   rsp_type     rsp_ff;
   logic        skip;

   slot_type chain [MaxTrackers];
   slot_type head_in, head_new;
   logic     shift;
   logic [31:0] dist_sq;
   logic [23:0] r16;
   logic [31:0] best_init;

   // Cell k feeds cell k+1; the last cell returns to cell 0 through head_in.
   for (genvar k = 0; k < MaxTrackers; k++) begin : g_cell
      ctt_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .shift   (shift),
         .slot_in ((k == 0) ? head_in : chain[(k + MaxTrackers - 1) % MaxTrackers]),
         .slot_out(chain[k])
      );
   end

   ctt_dist u_dist (
      .clock   (clock),
      .centre_x(item_ff.centre_x),
      .centre_y(item_ff.centre_y),
      .left    (chain[MaxTrackers-1].left),
      .top     (chain[MaxTrackers-1].top),
      .width   (chain[MaxTrackers-1].width),
      .height  (chain[MaxTrackers-1].height),
      .dist_sq (dist_sq)
   );

   assign r16 = {8'b0, radius_ff, 4'b0};
   assign best_init = {8'b0, r16} * {8'b0, r16};
   assign skip = item_ff.comp_area < min_area_ff;
   assign csr.ready = 1'b1;
   assign req.ready = (state_ff == ST_IDLE);
   assign rsp.valid = (state_ff == ST_OUT);
   assign rsp.data = rsp_ff;
   assign shift = (state_ff == ST_SCAN) || (state_ff == ST_UPDATE);

   // Slot passing the head in the update rotation: index = cnt_ff.
   logic [SlotW-1:0] cur_idx;
   logic             alloc;
   logic             hit_new;
   logic [8:0]       stab_inc;
   assign cur_idx = cnt_ff[SlotW-1:0];
   assign alloc = !found_ff && (next_slot_ff < CntW'(MaxTrackers));

   always_comb begin
      slot_type t;
      t = chain[MaxTrackers-1];
      head_new = t;
      hit_new = 1'b0;
      stab_inc = {1'b0, t.stable} + 9'd1;
      if (state_ff == ST_UPDATE && !skip) begin
         if (found_ff && cur_idx == best_idx_ff && !t.locked) begin
            if (item_ff.comp_area > t.max_area) begin
               head_new.left = item_ff.comp_left;
               head_new.top = item_ff.comp_top;
               head_new.width = item_ff.comp_width;
               head_new.height = item_ff.comp_height;
               head_new.max_area = item_ff.comp_area;
               head_new.stable = 8'd0;
            end else begin
               head_new.stable = stab_inc[8] ? 8'hFF : stab_inc[7:0];
               if (head_new.stable >= stab_ff) begin
                  head_new.locked = 1'b1;
                  hit_new = 1'b1;
               end
            end
         end else if (alloc && cur_idx == next_slot_ff[SlotW-1:0]) begin
            head_new.valid = 1'b1;
            head_new.left = item_ff.comp_left;
            head_new.top = item_ff.comp_top;
            head_new.width = item_ff.comp_width;
            head_new.height = item_ff.comp_height;
            head_new.max_area = item_ff.comp_area;
            head_new.stable = 8'd0;
            head_new.locked = 1'b0;
         end
      end
      head_in = head_new;
   end

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            cnt_in = '0;
            if (req.valid) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CntW'(MaxTrackers - 1)) state_in = ST_WAIT;
         end
         ST_WAIT: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CntW'(MaxTrackers + 1)) begin
               state_in = ST_UPDATE;
               cnt_in = '0;
            end
         end
         ST_UPDATE: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CntW'(MaxTrackers - 1)) state_in = ST_OUT;
         end
         ST_OUT: begin
            if (rsp.ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff <= '0;
         next_slot_ff <= '0;
         min_area_ff <= 23'd25;
         radius_ff <= 12'd50;
         stab_ff <= 8'd25;
         dist_vld_ff <= 1'b0;
         found_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         if (csr.valid) begin
            case (csr.data.index)
               CSR_MIN_AREA:  min_area_ff <= csr.data.data;
               CSR_RADIUS:    radius_ff <= csr.data.data[11:0];
               CSR_STABILITY: stab_ff <= csr.data.data[7:0];
               default: ;
            endcase
         end
         // Distance of the head slot is ready in the cycle after it is sampled.
         dist_vld_ff <= (state_ff == ST_SCAN);
         if (state_ff == ST_IDLE) begin
            found_ff <= 1'b0;
         end else if (dist_vld_ff && dist_slot_vld_ff && dist_sq < best_ff) begin
            found_ff <= 1'b1;
         end
         if (state_ff == ST_UPDATE && cnt_ff == CntW'(MaxTrackers - 1) && !skip && alloc) begin
            next_slot_ff <= next_slot_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) item_ff <= req.data;
      if (state_ff == ST_IDLE) best_ff <= best_init;
      else if (dist_vld_ff && dist_slot_vld_ff && dist_sq < best_ff) begin
         best_ff <= dist_sq;
         best_idx_ff <= dist_idx_ff;
      end
      dist_idx_ff <= cur_idx;
      dist_slot_vld_ff <= chain[MaxTrackers-1].valid;
      if (state_ff == ST_IDLE) begin
         rsp_ff <= '0;
      end else if (state_ff == ST_UPDATE) begin
         rsp_ff.was_skipped <= skip;
         rsp_ff.frame_done <= item_ff.last_in_frame;
         rsp_ff.table_full <= !skip && !found_ff && !alloc;
         rsp_ff.is_new <= !skip && alloc;
         if (!skip && head_new.valid && ((found_ff && cur_idx == best_idx_ff) ||
             (alloc && cur_idx == next_slot_ff[SlotW-1:0]))) begin
            rsp_ff.track_id <= IdW'(cur_idx) + 1'b1;
            rsp_ff.locked_now <= hit_new;
            rsp_ff.is_locked <= head_new.locked;
            rsp_ff.stable_count <= head_new.stable;
            rsp_ff.box_left <= head_new.left;
            rsp_ff.box_top <= head_new.top;
            rsp_ff.box_width <= head_new.width;
            rsp_ff.box_height <= head_new.height;
         end
      end
   end
endmodule
`default_nettype wire
